/* rtl/core/nbp_pkg.sv */
// ----------------------------------------------------------------------------
// nbp_pkg
// Shared types and constants for the nearest boundary point block: store
// geometry, command codes, sequencer states and the beat layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package nbp_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_SHAPES   = 64;
   localparam int COORD_BITS   = 16;

   localparam int ADDR_W  = $clog2(MAX_VERTICES);
   localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
   localparam int SHAPE_W = 6;
   localparam int POS_W   = 8;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BEST,
      ST_RD,
      ST_LATCH,
      ST_LEN_A,
      ST_LEN_B,
      ST_DOT_A,
      ST_DOT_B,
      ST_T,
      ST_DIV,
      ST_PNT_X,
      ST_PNT_Z,
      ST_DST_X,
      ST_DST_Z,
      ST_CMP,
      ST_SQI,
      ST_SQRT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [5:0]         vertex_shape;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_z;
      logic [15:0]        tolerance;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [5:0]         hit_shape;
      logic [7:0]         hit_edge;
      logic [16:0]        hit_t;
      logic signed [15:0] point_x;
      logic signed [15:0] point_z;
      logic [16:0]        distance;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        x;
      logic [15:0]        z;
      logic [SHAPE_W-1:0] shape;
      logic [POS_W-1:0]   pos;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/core/nearest_boundary_point.sv */
// ----------------------------------------------------------------------------
// nearest_boundary_point
// Vertex store plus a sequencer that walks every stored edge through one
// shared 18x18 multiplier, a 16-step restoring divider for t and a final
// 18-step integer square root of the winning squared distance.
// ----------------------------------------------------------------------------
// Clear and append are taken only while the sequencer is idle. A query's
// duration grows with the number of stored vertices and same-shape edges, and
// is shorter for an edge whose t clamps, since the divider is then skipped.
// One item is worked at a time.
// Synchronous active-high reset empties the store and idles the sequencer;
// the vertex RAM itself is not cleared.
`default_nettype none

module nearest_boundary_point (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire nbp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output nbp_pkg::rsp_type      rsp_data
);

   import nbp_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] count_ff, rd_idx_ff;
   logic [SHAPE_W-1:0] last_shape_ff;
   logic [POS_W-1:0]   last_pos_ff;

   entry_type a_ff, b_ff, rd_entry, wr_entry;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;

   logic signed [15:0] px_ff, pz_ff;
   logic signed [17:0] opa, opb;
   logic signed [35:0] prod_ff;
   logic signed [36:0] acc_ff, len2_ff, best_ff, d2_ff;
   logic signed [36:0] sum37;
   logic [36:0]        rem_ff, rem2;
   logic [15:0]        q_ff;
   logic [3:0]         div_cnt_ff;
   logic [16:0]        t_ff;
   logic [15:0]        cx_ff, cz_ff;
   logic signed [35:0] rsum;
   logic [17:0]        pnt;

   logic        found_ff;
   logic [5:0]  r_shape_ff;
   logic [7:0]  r_edge_ff;
   logic [16:0] r_t_ff;
   logic [15:0] r_x_ff, r_z_ff;

   logic [35:0] sq_n_ff;
   logic [20:0] sq_rem_ff, sq_sh, sq_trial;
   logic [17:0] sq_root_ff;
   logic [4:0]  sq_cnt_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic signed [16:0] abx, abz, pax, paz, dx, dz;
   logic               accept, rsp_free, more_edges, edge_ok;

   nbp_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_VERTICES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   assign accept     = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign more_edges = (COUNT_W'(rd_idx_ff + 1'b1) < count_ff);
   assign edge_ok    = (b_ff.shape == rd_entry.shape);

   assign abx = {b_ff.x[15], b_ff.x} - {a_ff.x[15], a_ff.x};
   assign abz = {b_ff.z[15], b_ff.z} - {a_ff.z[15], a_ff.z};
   assign pax = {px_ff[15], px_ff} - {a_ff.x[15], a_ff.x};
   assign paz = {pz_ff[15], pz_ff} - {a_ff.z[15], a_ff.z};
   assign dx  = {cx_ff[15], cx_ff} - {px_ff[15], px_ff};
   assign dz  = {cz_ff[15], cz_ff} - {pz_ff[15], pz_ff};

   assign sum37 = acc_ff + {prod_ff[35], prod_ff};
   assign rem2  = {rem_ff[35:0], 1'b0};
   // Floor of (product + half) / 65536, i.e. round half up.
   assign rsum  = prod_ff + 36'sd32768;

   assign sq_sh    = {sq_rem_ff[18:0], sq_n_ff[35:34]};
   assign sq_trial = {1'b0, sq_root_ff, 2'b01};

   // New vertex: continue the position run when the shape matches the last one.
   always_comb begin
      wr_entry.x     = req_data.coord_x;
      wr_entry.z     = req_data.coord_z;
      wr_entry.shape = req_data.vertex_shape;
      wr_entry.pos   = '0;
      if (count_ff != '0 && last_shape_ff == req_data.vertex_shape) begin
         wr_entry.pos = POS_W'(last_pos_ff + 1'b1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_QUERY) begin
               state_in = ST_BEST;
            end
         end
         ST_BEST:  state_in = (count_ff < COUNT_W'(2)) ? ST_SQI : ST_RD;
         ST_RD:    state_in = ST_LATCH;
         ST_LATCH: begin
            if (rd_idx_ff == '0) begin
               state_in = ST_RD;
            end else if (edge_ok) begin
               state_in = ST_LEN_A;
            end else begin
               state_in = more_edges ? ST_RD : ST_SQI;
            end
         end
         ST_LEN_A: state_in = ST_LEN_B;
         ST_LEN_B: state_in = ST_DOT_A;
         ST_DOT_A: state_in = ST_DOT_B;
         ST_DOT_B: state_in = ST_T;
         ST_T: begin
            if (len2_ff == '0 || sum37 <= 0 || sum37 >= len2_ff) begin
               state_in = ST_PNT_X;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:   state_in = (div_cnt_ff == 4'd15) ? ST_PNT_X : ST_DIV;
         ST_PNT_X: state_in = ST_PNT_Z;
         ST_PNT_Z: state_in = ST_DST_X;
         ST_DST_X: state_in = ST_DST_Z;
         ST_DST_Z: state_in = ST_CMP;
         ST_CMP:   state_in = more_edges ? ST_RD : ST_SQI;
         ST_SQI:   state_in = ST_SQRT;
         ST_SQRT:  state_in = (sq_cnt_ff == 5'd17) ? ST_DONE : ST_SQRT;
         ST_DONE:  state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      wr_en     = accept && req_data.cmd == CMD_APPEND &&
                  count_ff < COUNT_W'(MAX_VERTICES);
      rd_addr   = rd_idx_ff[ADDR_W-1:0];
      opa       = '0;
      opb       = '0;
      case (state_ff)
         ST_IDLE: begin
            opa = {2'b00, req_data.tolerance};
            opb = {2'b00, req_data.tolerance};
         end
         ST_LEN_A: begin
            opa = {abx[16], abx};
            opb = {abx[16], abx};
         end
         ST_LEN_B: begin
            opa = {abz[16], abz};
            opb = {abz[16], abz};
         end
         ST_DOT_A: begin
            opa = {pax[16], pax};
            opb = {abx[16], abx};
         end
         ST_DOT_B: begin
            opa = {paz[16], paz};
            opb = {abz[16], abz};
         end
         ST_PNT_X: begin
            opa = {abx[16], abx};
            opb = {1'b0, t_ff};
         end
         ST_PNT_Z: begin
            opa = {abz[16], abz};
            opb = {1'b0, t_ff};
         end
         ST_DST_X: begin
            opa = {dx[16], dx};
            opb = {dx[16], dx};
         end
         ST_DST_Z: begin
            opa = {dz[16], dz};
            opb = {dz[16], dz};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign pnt = rsum[33:16];

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_QUERY) begin
               px_ff      <= req_data.coord_x;
               pz_ff      <= req_data.coord_z;
               r_shape_ff <= '0;
               r_edge_ff  <= '0;
               r_t_ff     <= '0;
               r_x_ff     <= '0;
               r_z_ff     <= '0;
               d2_ff      <= '0;
            end
         end
         ST_BEST: best_ff <= {prod_ff[35], prod_ff};
         ST_LATCH: begin
            a_ff <= b_ff;
            b_ff <= rd_entry;
         end
         ST_LEN_B: acc_ff <= {prod_ff[35], prod_ff};
         ST_DOT_A: len2_ff <= sum37;
         ST_DOT_B: acc_ff <= {prod_ff[35], prod_ff};
         ST_T: begin
            rem_ff     <= sum37;
            q_ff       <= '0;
            div_cnt_ff <= '0;
            if (len2_ff == '0 || sum37 <= 0) begin
               t_ff <= '0;
            end else begin
               t_ff <= 17'h10000;
            end
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + 4'd1;
            if (rem2 >= len2_ff) begin
               rem_ff <= rem2 - len2_ff;
               q_ff   <= {q_ff[14:0], 1'b1};
               t_ff   <= {1'b0, q_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem2;
               q_ff   <= {q_ff[14:0], 1'b0};
               t_ff   <= {1'b0, q_ff[14:0], 1'b0};
            end
         end
         ST_PNT_Z: cx_ff <= 16'({a_ff.x[15], a_ff.x[15], a_ff.x} + pnt);
         ST_DST_X: cz_ff <= 16'({a_ff.z[15], a_ff.z[15], a_ff.z} + pnt);
         ST_DST_Z: acc_ff <= {prod_ff[35], prod_ff};
         ST_CMP: begin
            // Inclusive compare, so a later edge at equal distance wins.
            if (sum37 <= best_ff) begin
               best_ff    <= sum37;
               d2_ff      <= sum37;
               r_shape_ff <= a_ff.shape;
               r_edge_ff  <= a_ff.pos;
               r_t_ff     <= t_ff;
               r_x_ff     <= cx_ff;
               r_z_ff     <= cz_ff;
            end
         end
         ST_SQI: begin
            sq_n_ff    <= d2_ff[35:0];
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
            sq_cnt_ff  <= '0;
         end
         ST_SQRT: begin
            sq_n_ff   <= {sq_n_ff[33:0], 2'b00};
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
            if (sq_sh >= sq_trial) begin
               sq_rem_ff  <= sq_sh - sq_trial;
               sq_root_ff <= {sq_root_ff[16:0], 1'b1};
            end else begin
               sq_rem_ff  <= sq_sh;
               sq_root_ff <= {sq_root_ff[16:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ff.found     <= found_ff;
         rsp_ff.hit_shape <= r_shape_ff;
         rsp_ff.hit_edge  <= r_edge_ff;
         rsp_ff.hit_t     <= r_t_ff;
         rsp_ff.point_x   <= r_x_ff;
         rsp_ff.point_z   <= r_z_ff;
         rsp_ff.distance  <= sq_root_ff[16:0];
      end
      if (wr_en) begin
         last_shape_ff <= req_data.vertex_shape;
         last_pos_ff   <= wr_entry.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req_data.cmd == CMD_CLEAR) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_BEST) begin
            rd_idx_ff <= '0;
            found_ff  <= 1'b0;
         end else if (state_ff == ST_LATCH && rd_idx_ff == '0) begin
            rd_idx_ff <= COUNT_W'(1);
         end else if ((state_ff == ST_LATCH && !edge_ok) || state_ff == ST_CMP) begin
            if (more_edges) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
         end
         if (state_ff == ST_CMP && sum37 <= best_ff) begin
            found_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   a_append_count : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("append did not advance the vertex count");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("result beat not issued on query completion");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.hit_t == '0 && rsp_ff.distance == '0))
      else $error("miss beat carries nonzero fields");

   a_t_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.hit_t <= 17'h10000)
      else $error("edge parameter above one");

endmodule

`default_nettype wire

/* rtl/core/nbp_ram.sv */
// ----------------------------------------------------------------------------
// nbp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
